>>> design/ble_pkg.sv
// ----------------------------------------------------------------------------
// ble_pkg
// Shared types, constants and the boolean function table for the boolean
// limb engine.
// ----------------------------------------------------------------------------
package ble_pkg;

  // Width of the limb ports
  localparam int unsigned PORT_BITS = 64;
  // Limb bits that take part in the operation (8 .. 64)
  localparam int unsigned LIMB_BITS = 64;

  typedef logic [LIMB_BITS-1:0] limb_t;

  // Two-operand boolean functions
  typedef enum logic [3:0] {
    FN_CLR   = 4'd0,
    FN_SET   = 4'd1,
    FN_A     = 4'd2,
    FN_B     = 4'd3,
    FN_NOTA  = 4'd4,
    FN_NOTB  = 4'd5,
    FN_AND   = 4'd6,
    FN_IOR   = 4'd7,
    FN_XOR   = 4'd8,
    FN_EQV   = 4'd9,
    FN_NAND  = 4'd10,
    FN_NOR   = 4'd11,
    FN_ANDC1 = 4'd12,
    FN_ANDC2 = 4'd13,
    FN_ORC1  = 4'd14,
    FN_ORC2  = 4'd15
  } func_e;

  // One input item as held in the input register
  typedef struct packed {
    func_e func;
    limb_t a_limb;
    logic  a_present;
    logic  a_negative;
    limb_t b_limb;
    logic  b_present;
    logic  b_negative;
    logic  final_limb;
  } item_t;

  // Apply a boolean function bitwise
  function automatic limb_t apply_func(func_e f, limb_t x, limb_t y);
    limb_t r;
    unique case (f)
      FN_CLR:   r = '0;
      FN_SET:   r = '1;
      FN_A:     r = x;
      FN_B:     r = y;
      FN_NOTA:  r = ~x;
      FN_NOTB:  r = ~y;
      FN_AND:   r = x & y;
      FN_IOR:   r = x | y;
      FN_XOR:   r = x ^ y;
      FN_EQV:   r = ~(x ^ y);
      FN_NAND:  r = ~(x & y);
      FN_NOR:   r = ~(x | y);
      FN_ANDC1: r = ~x & y;
      FN_ANDC2: r = x & ~y;
      FN_ORC1:  r = ~x | y;
      FN_ORC2:  r = x | ~y;
      default:  r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> design/ble_tc_limb.sv
// ----------------------------------------------------------------------------
// ble_tc_limb
// Two's-complement view of one sign-magnitude limb, with the pending +1
// carry of the negation tracked by a done flag.
// ----------------------------------------------------------------------------
module ble_tc_limb (
  input  ble_pkg::limb_t mag_i,
  input  logic           present_i,
  input  logic           negative_i,
  input  logic           done_i,
  output ble_pkg::limb_t value_o,
  output logic           done_o
);
  import ble_pkg::*;

  limb_t inv;

  assign inv = ~mag_i;

  // Absent limbs read as sign extension; a zero magnitude keeps the carry
  // pending (its negation is zero, which ~0 + 1 gives as well)
  always_comb begin
    value_o = mag_i;
    done_o  = done_i;
    if (!present_i) begin
      value_o = negative_i ? '1 : '0;
    end else if (negative_i) begin
      if (done_i) begin
        value_o = inv;
      end else begin
        value_o = inv + limb_t'(1);
        done_o  = |mag_i;
      end
    end
  end

endmodule

>>> design/ble_core.sv
// ----------------------------------------------------------------------------
// ble_core
// Compute stage: converts both operands, applies the function, converts a
// negative result back to magnitude, and holds the three carry flags and
// the result register.
// ----------------------------------------------------------------------------
module ble_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  ble_pkg::item_t                 item_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic [ble_pkg::PORT_BITS-1:0]  result_limb_o,
  output logic                           result_negative_o,
  output logic                           result_last_o
);
  import ble_pkg::*;

  logic  a_done_q, b_done_q, r_done_q;
  logic  a_done_d, b_done_d, r_done_d;
  logic  a_done_n, b_done_n, r_done_n;
  limb_t x, y, r_tc, r_mag;
  limb_t sign_mask;
  logic  r_neg;
  logic  fire;
  logic  valid_q;
  limb_t limb_q;
  logic  neg_q, last_q;

  // Operand conversion
  ble_tc_limb u_conv_a (
    .mag_i      (item_i.a_limb),
    .present_i  (item_i.a_present),
    .negative_i (item_i.a_negative),
    .done_i     (a_done_q),
    .value_o    (x),
    .done_o     (a_done_n)
  );

  ble_tc_limb u_conv_b (
    .mag_i      (item_i.b_limb),
    .present_i  (item_i.b_present),
    .negative_i (item_i.b_negative),
    .done_i     (b_done_q),
    .value_o    (y),
    .done_o     (b_done_n)
  );

  // Result sign from the operands' sign masks
  assign sign_mask = apply_func(item_i.func,
                                item_i.a_negative ? '1 : '0,
                                item_i.b_negative ? '1 : '0);
  assign r_neg = sign_mask[0];
  assign r_tc  = apply_func(item_i.func, x, y);

  // Back to magnitude for a negative result
  ble_tc_limb u_conv_r (
    .mag_i      (r_tc),
    .present_i  (1'b1),
    .negative_i (r_neg),
    .done_i     (r_done_q),
    .value_o    (r_mag),
    .done_o     (r_done_n)
  );

  // Advance when the result register is free or being drained
  assign ready_o = !valid_q || ready_i;
  assign fire    = valid_i && ready_o;

  // Clear all carries after the final limb
  always_comb begin
    a_done_d = a_done_q;
    b_done_d = b_done_q;
    r_done_d = r_done_q;
    if (fire) begin
      if (item_i.final_limb) begin
        a_done_d = 1'b0;
        b_done_d = 1'b0;
        r_done_d = 1'b0;
      end else begin
        a_done_d = a_done_n;
        b_done_d = b_done_n;
        r_done_d = r_done_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_done_q <= 1'b0;
      b_done_q <= 1'b0;
      r_done_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      a_done_q <= a_done_d;
      b_done_q <= b_done_d;
      r_done_q <= r_done_d;
      if (ready_o) begin
        valid_q <= valid_i;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (fire) begin
      limb_q <= r_mag;
      neg_q  <= r_neg;
      last_q <= item_i.final_limb;
    end
  end

  assign valid_o           = valid_q;
  assign result_limb_o     = PORT_BITS'(limb_q);
  assign result_negative_o = neg_q;
  assign result_last_o     = last_q;

endmodule

>>> design/bignum_boolean_limb_engine.sv
// ----------------------------------------------------------------------------
// bignum_boolean_limb_engine
// Boolean function on two sign-magnitude integers streamed one limb at a
// time in their two's-complement view.
// ----------------------------------------------------------------------------
// Path: input register, then the compute stage into the result register.
// Throughput: one limb per cycle while the output is not stalled; the carry
//   flags loop within the compute stage.
// Reset: rst_ni clears the valid bits and all three carry flags (carries
//   pending); the input is ready during reset and right after its release.
// ----------------------------------------------------------------------------
module bignum_boolean_limb_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [3:0]                    func_i,
  input  logic [ble_pkg::PORT_BITS-1:0] a_limb_i,
  input  logic                          a_present_i,
  input  logic                          a_negative_i,
  input  logic [ble_pkg::PORT_BITS-1:0] b_limb_i,
  input  logic                          b_present_i,
  input  logic                          b_negative_i,
  input  logic                          final_limb_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ble_pkg::PORT_BITS-1:0] result_limb_o,
  output logic                          result_negative_o,
  output logic                          result_last_o
);
  import ble_pkg::*;

  logic  in_valid_q;
  item_t item_q;
  logic  core_ready;

  // Input register advances when the compute stage takes its item
  assign in_ready_o = !in_valid_q || core_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Capture the item, dropping limb bits above the limb width
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.func       <= func_e'(func_i);
      item_q.a_limb     <= a_limb_i[LIMB_BITS-1:0];
      item_q.a_present  <= a_present_i;
      item_q.a_negative <= a_negative_i;
      item_q.b_limb     <= b_limb_i[LIMB_BITS-1:0];
      item_q.b_present  <= b_present_i;
      item_q.b_negative <= b_negative_i;
      item_q.final_limb <= final_limb_i;
    end
  end

  ble_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (in_valid_q),
    .ready_o           (core_ready),
    .item_i            (item_q),
    .valid_o           (out_valid_o),
    .ready_i           (out_ready_i),
    .result_limb_o     (result_limb_o),
    .result_negative_o (result_negative_o),
    .result_last_o     (result_last_o)
  );

endmodule

>>> design/ble_checker.sv
// ----------------------------------------------------------------------------
// ble_checker
// Port-level checks of the boolean limb engine, bound to the top level.
// ----------------------------------------------------------------------------
module ble_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [ble_pkg::PORT_BITS-1:0] result_limb_o,
  input logic                          result_negative_o,
  input logic                          result_last_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_limb_o) &&
      $stable(result_negative_o) && $stable(result_last_o))
    else $error("stalled result changed");

  // The input side only stalls behind a full, stalled output
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while output could drain");

  // An accepted item passes the input register into the result register when not blocked
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) ##1 out_ready_i |=> out_valid_o)
    else $error("accepted item did not reach the output");

endmodule

bind bignum_boolean_limb_engine ble_checker u_ble_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .result_limb_o     (result_limb_o),
  .result_negative_o (result_negative_o),
  .result_last_o     (result_last_o)
);

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bignum_boolean_limb_engine. Streams limbs of
// sign-magnitude operand pairs, predicts every result limb from a local
// two's-complement model with its own carry flags, and compares each
// accepted result limb field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  import ble_pkg::*;

  typedef logic [PORT_BITS-1:0] port_t;

  typedef struct packed {
    port_t limb;
    logic  negative;
    logic  last;
  } limb_result_t;

  localparam int unsigned STALL_LIMIT = 5000;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Block inputs, known from time zero
  logic  in_valid     = 1'b0;
  logic  out_ready    = 1'b0;
  logic  [3:0] func_sel = '0;
  port_t a_limb       = '0;
  logic  a_present    = 1'b0;
  logic  a_negative   = 1'b0;
  port_t b_limb       = '0;
  logic  b_present    = 1'b0;
  logic  b_negative   = 1'b0;
  logic  final_limb   = 1'b0;

  logic  in_ready_o;
  logic  out_valid_o;
  port_t result_limb_o;
  logic  result_negative_o;
  logic  result_last_o;

  bignum_boolean_limb_engine u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready_o),
    .func_i            (func_sel),
    .a_limb_i          (a_limb),
    .a_present_i       (a_present),
    .a_negative_i      (a_negative),
    .b_limb_i          (b_limb),
    .b_present_i       (b_present),
    .b_negative_i      (b_negative),
    .final_limb_i      (final_limb),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready),
    .result_limb_o     (result_limb_o),
    .result_negative_o (result_negative_o),
    .result_last_o     (result_last_o)
  );

  // Shared bench state
  limb_result_t pending_results[$];
  int unsigned  send_idle_pct  = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  items_sent     = 0;
  int unsigned  ops_sent       = 0;
  int unsigned  results_seen   = 0;
  int unsigned  error_count    = 0;
  int unsigned  quiet_cycles   = 0;

  // Predictor carry flags: 1 once the +1 of a negation has been absorbed
  logic a_inc_done = 1'b0;
  logic b_inc_done = 1'b0;
  logic r_inc_done = 1'b0;

  // Truth table of a function, indexed by {x bit, y bit}
  function automatic logic [3:0] truth_of(func_e f);
    case (f)
      FN_CLR:   return 4'b0000;
      FN_SET:   return 4'b1111;
      FN_A:     return 4'b1100;
      FN_B:     return 4'b1010;
      FN_NOTA:  return 4'b0011;
      FN_NOTB:  return 4'b0101;
      FN_AND:   return 4'b1000;
      FN_IOR:   return 4'b1110;
      FN_XOR:   return 4'b0110;
      FN_EQV:   return 4'b1001;
      FN_NAND:  return 4'b0111;
      FN_NOR:   return 4'b0001;
      FN_ANDC1: return 4'b0010;
      FN_ANDC2: return 4'b0100;
      FN_ORC1:  return 4'b1011;
      default:  return 4'b1101;
    endcase
  endfunction

  // Two's-complement view of one magnitude limb; returns {carry_done, limb}
  function automatic logic [LIMB_BITS:0] twos_view(limb_t mag, logic present,
                                                   logic neg, logic done);
    limb_t v;
    logic  d;
    d = done;
    if (!present) v = neg ? '1 : '0;
    else if (!neg) v = mag;
    else if (done) v = ~mag;
    else if (mag == '0) v = '0;
    else begin
      v = ~mag + 1'b1;
      d = 1'b1;
    end
    return {d, v};
  endfunction

  // Predict the result limb of one accepted item and advance the flags
  task automatic predict_limb(output limb_result_t res);
    logic [3:0]       tt;
    logic [LIMB_BITS:0] xa, yb, rr;
    limb_t            x, y, r;
    logic             r_neg;
    tt = truth_of(func_e'(func_sel));
    xa = twos_view(a_limb[LIMB_BITS-1:0], a_present, a_negative, a_inc_done);
    yb = twos_view(b_limb[LIMB_BITS-1:0], b_present, b_negative, b_inc_done);
    a_inc_done = xa[LIMB_BITS];
    b_inc_done = yb[LIMB_BITS];
    x = xa[LIMB_BITS-1:0];
    y = yb[LIMB_BITS-1:0];
    r = ( x &  y & {LIMB_BITS{tt[3]}}) | ( x & ~y & {LIMB_BITS{tt[2]}}) |
        (~x &  y & {LIMB_BITS{tt[1]}}) | (~x & ~y & {LIMB_BITS{tt[0]}});
    r_neg = tt[{a_negative, b_negative}];
    if (r_neg) begin
      rr = twos_view(r, 1'b1, 1'b1, r_inc_done);
      r_inc_done = rr[LIMB_BITS];
      r = rr[LIMB_BITS-1:0];
    end
    res.limb     = port_t'(r);
    res.negative = r_neg;
    res.last     = final_limb;
    if (final_limb) begin
      a_inc_done = 1'b0;
      b_inc_done = 1'b0;
      r_inc_done = 1'b0;
    end
  endtask

  task automatic report_field(string name, port_t want, port_t got);
    if (want !== got) begin
      error_count++;
      if (error_count <= 30)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Record accepted items, check accepted results, watch for a hang
  always @(posedge clk_i) begin
    limb_result_t res;
    limb_result_t want;
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        predict_limb(res);
        pending_results.push_back(res);
      end
      if (out_valid_o && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          error_count++;
          if (error_count <= 30)
            $display("%0t: unexpected result, expected none, actual %h", $time,
                     result_limb_o);
        end else begin
          want = pending_results.pop_front();
          report_field("result_limb", want.limb, result_limb_o);
          report_field("result_negative", port_t'(want.negative),
                       port_t'(result_negative_o));
          report_field("result_last", port_t'(want.last), port_t'(result_last_o));
        end
      end
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Receiver stalls at the current rate
  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Send one item, holding it until accepted
  task automatic send_limb(input func_e f, input port_t a, input logic ap, an,
                           input port_t b, input logic bp, bn, fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    func_sel   <= f;
    a_limb     <= a;
    a_present  <= ap;
    a_negative <= an;
    b_limb     <= b;
    b_present  <= bp;
    b_negative <= bn;
    final_limb <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Hold the sender until every expected result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic port_t rand_limb();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) return '0;
    if (pick < 40) return '1;
    if (pick < 50) return port_t'(1);
    if (pick < 60) return port_t'(1) << (LIMB_BITS - 1);
    return port_t'({$urandom, $urandom});
  endfunction

  function automatic int unsigned rand_len();
    if ($urandom_range(9) == 0) return $urandom_range(8);
    return $urandom_range(3);
  endfunction

  // Stream one operation; n_limbs may cut it short, flip_signs breaks it
  task automatic send_operation(input func_e f, input int unsigned la, lb,
                                input logic an, bn, input int unsigned n_limbs,
                                input bit flip_signs);
    port_t a, b;
    logic  sa, sb;
    for (int unsigned i = 0; i < n_limbs; i++) begin
      a  = (i < la) ? rand_limb() : port_t'({$urandom, $urandom});
      b  = (i < lb) ? rand_limb() : port_t'({$urandom, $urandom});
      sa = (flip_signs && ($urandom_range(1) != 0)) ? ~an : an;
      sb = (flip_signs && ($urandom_range(1) != 0)) ? ~bn : bn;
      send_limb(f, a, i < la, sa, b, i < lb, sb, i == n_limbs - 1);
    end
    ops_sent++;
  endtask

  // Every function once on a single final limb, extreme values and all signs
  task automatic test_each_function();
    port_t extremes[4];
    extremes[0] = '1;
    extremes[1] = '0;
    extremes[2] = port_t'(1);
    extremes[3] = port_t'(1) << (LIMB_BITS - 1);
    for (int f = 0; f < 16; f++) begin
      send_limb(func_e'(f), extremes[f % 4], 1'b1, f[0], extremes[(f / 4) % 4],
                1'b1, f[1], 1'b1);
      ops_sent++;
    end
  endtask

  // Negation carry rippling through zero limbs, absent limbs, negative result
  task automatic test_carry_ripple();
    // a = -(2**(2*LIMB_BITS)), b = -1
    send_limb(FN_AND, '0, 1'b1, 1'b1, port_t'(1), 1'b1, 1'b1, 1'b0);
    send_limb(FN_AND, '0, 1'b1, 1'b1, '1, 1'b0, 1'b1, 1'b0);
    send_limb(FN_AND, port_t'(1), 1'b1, 1'b1, '1, 1'b0, 1'b1, 1'b0);
    send_limb(FN_AND, '1, 1'b0, 1'b1, '0, 1'b0, 1'b1, 1'b1);
    // nor of two zeros gives -1
    send_limb(FN_NOR, '0, 1'b1, 1'b0, '0, 1'b1, 1'b0, 1'b0);
    send_limb(FN_NOR, '0, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b1);
    ops_sent += 2;
  endtask

  // Signs that change between limbs of one operation
  task automatic test_sign_change();
    send_limb(FN_XOR, '0, 1'b1, 1'b1, port_t'(5), 1'b1, 1'b0, 1'b0);
    send_limb(FN_XOR, port_t'(3), 1'b1, 1'b0, port_t'(7), 1'b1, 1'b1, 1'b1);
    ops_sent++;
  endtask

  // Mostly well-formed operations, some broken ones, some pure noise
  task automatic test_random_traffic(input int unsigned idle_pct, stall_pct,
                                     input int unsigned n_items);
    int unsigned start, kind, la, lb, n;
    start          = items_sent;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (items_sent - start < n_items) begin
      kind = $urandom_range(99);
      la   = rand_len();
      lb   = rand_len();
      n    = ((la > lb) ? la : lb) + 1;
      if (kind < 80) begin
        send_operation(func_e'($urandom_range(15)), la, lb, 1'($urandom_range(1)),
                       1'($urandom_range(1)), n, 1'b0);
      end else if (kind < 90) begin
        send_operation(func_e'($urandom_range(15)), la, lb, 1'($urandom_range(1)),
                       1'($urandom_range(1)), $urandom_range(1, n),
                       1'($urandom_range(1)));
      end else begin
        send_limb(func_e'($urandom_range(15)), port_t'({$urandom, $urandom}),
                  1'($urandom_range(1)), 1'($urandom_range(1)),
                  port_t'({$urandom, $urandom}), 1'($urandom_range(1)),
                  1'($urandom_range(1)), $urandom_range(3) == 0);
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_each_function();
    test_carry_ripple();
    test_sign_change();
    wait_drained();

    test_random_traffic(0, 0, 330);
    test_random_traffic(56, 0, 320);
    test_random_traffic(0, 56, 320);
    test_random_traffic(7, 7, 320);

    // Let any stray result show up
    in_valid <= 1'b0;
    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      error_count++;
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
    end

    $display("Sent %0d limbs in %0d operations (all 16 functions, mixed signs, ragged",
             items_sent, ops_sent);
    $display("lengths) under four idle/stall profiles; checked %0d result limbs.",
             results_seen);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
